// ----- rtl/core/slps_pkg.sv -----
// Shared constants, types and pattern tables of the status light pattern sequencer.
package slps_pkg;

    // Colour codes.
    localparam logic [3:0] C_NONE   = 4'd0;
    localparam logic [3:0] C_BLACK  = 4'd1;
    localparam logic [3:0] C_RED    = 4'd2;
    localparam logic [3:0] C_ORANGE = 4'd3;
    localparam logic [3:0] C_YELLOW = 4'd4;
    localparam logic [3:0] C_GREEN  = 4'd5;
    localparam logic [3:0] C_BLUE   = 4'd6;
    localparam logic [3:0] C_HUB_LO = 4'd2;
    localparam logic [3:0] C_HUB_HI = 4'd8;
    // Placeholders in the Bluetooth table for the two hub colour registers.
    localparam logic [3:0] C_HUB1   = 4'd14;
    localparam logic [3:0] C_HUB2   = 4'd15;

    // Special durations.
    localparam logic [7:0] DUR_REPEAT  = 8'd0;
    localparam logic [7:0] DUR_FOREVER = 8'd255;

    // Pattern lengths, in elements.
    localparam logic [2:0] WARN_LEN = 3'd5;
    localparam logic [3:0] BLE_LEN  = 4'd9;
    localparam logic [1:0] BATT_LEN = 2'd3;

    // Warning indications.
    localparam logic [2:0] WARN_NONE         = 3'd0;
    localparam logic [2:0] WARN_HIGH_CURRENT = 3'd1;
    localparam logic [2:0] WARN_LOW_VOLTAGE  = 3'd2;
    localparam logic [2:0] WARN_SHUTDOWN_REQ = 3'd3;
    localparam logic [2:0] WARN_SHUTDOWN     = 3'd4;
    localparam logic [2:0] WARN_KINDS        = 3'd5;

    // Bluetooth indications.
    localparam logic [1:0] BLE_NONE        = 2'd0;
    localparam logic [1:0] BLE_ADVERTISING = 2'd1;
    localparam logic [1:0] BLE_CONNECTED   = 2'd2;
    localparam logic [1:0] BLE_KINDS       = 2'd3;

    // Battery indications.
    localparam logic [2:0] BATT_DISCHARGING = 3'd0;
    localparam logic [2:0] BATT_CHARGING    = 3'd1;
    localparam logic [2:0] BATT_FULL        = 3'd2;
    localparam logic [2:0] BATT_OVERCHARGE  = 3'd3;
    localparam logic [2:0] BATT_FAULT       = 3'd4;

    // Charger states.
    localparam logic [1:0] CHG_DISCHARGING = 2'd0;
    localparam logic [1:0] CHG_CHARGING    = 2'd1;
    localparam logic [1:0] CHG_COMPLETE    = 2'd2;
    localparam logic [1:0] CHG_FAULT       = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEPARATE_BLE  = 2'd0;
    localparam logic [1:0] REG_SHOW_SD_REQ   = 2'd1;
    localparam logic [1:0] REG_FIRST_HUB     = 2'd2;
    localparam logic [1:0] REG_SECOND_HUB    = 2'd3;

    typedef struct packed {
        logic [3:0] color;
        logic [7:0] dur;
    } t_elem;

    // Warning pattern table.
    function automatic t_elem warn_rom(input logic [2:0] kind, input logic [2:0] step);
        t_elem e;
        e = '{color: C_NONE, dur: DUR_REPEAT};
        case (kind)
            WARN_NONE: begin
                if (step == 3'd0) e = '{color: C_NONE, dur: DUR_FOREVER};
            end
            WARN_HIGH_CURRENT, WARN_LOW_VOLTAGE: begin
                case (step)
                    3'd0, 3'd2: e = '{color: (kind == WARN_HIGH_CURRENT) ? C_RED : C_ORANGE,
                                      dur: 8'd2};
                    3'd1: e = '{color: C_NONE, dur: 8'd2};
                    3'd3: e = '{color: C_NONE, dur: 8'd22};
                    default: e = '{color: C_NONE, dur: DUR_REPEAT};
                endcase
            end
            WARN_SHUTDOWN_REQ: begin
                case (step)
                    3'd0: e = '{color: C_BLACK, dur: 8'd1};
                    3'd1: e = '{color: C_BLUE, dur: 8'd1};
                    default: e = '{color: C_NONE, dur: DUR_REPEAT};
                endcase
            end
            WARN_SHUTDOWN: begin
                if (step == 3'd0) e = '{color: C_BLACK, dur: DUR_FOREVER};
            end
            default: e = '{color: C_NONE, dur: DUR_REPEAT};
        endcase
        return e;
    endfunction

    // Bluetooth pattern table.
    function automatic t_elem ble_rom(input logic [1:0] kind, input logic [3:0] step);
        t_elem e;
        e = '{color: C_NONE, dur: DUR_REPEAT};
        case (kind)
            BLE_NONE: begin
                if (step == 4'd0) e = '{color: C_NONE, dur: DUR_FOREVER};
            end
            BLE_ADVERTISING: begin
                case (step)
                    4'd0: e = '{color: C_HUB1, dur: 8'd3};
                    4'd1: e = '{color: C_BLACK, dur: 8'd5};
                    4'd2: e = '{color: C_HUB2, dur: 8'd3};
                    4'd3: e = '{color: C_BLACK, dur: 8'd12};
                    default: e = '{color: C_NONE, dur: DUR_REPEAT};
                endcase
            end
            BLE_CONNECTED: begin
                case (step)
                    4'd0, 4'd2: e = '{color: C_HUB1, dur: 8'd2};
                    4'd4, 4'd6: e = '{color: C_HUB2, dur: 8'd2};
                    4'd1, 4'd5: e = '{color: C_BLACK, dur: 8'd2};
                    4'd3, 4'd7: e = '{color: C_BLACK, dur: 8'd8};
                    default: e = '{color: C_NONE, dur: DUR_REPEAT};
                endcase
            end
            default: e = '{color: C_NONE, dur: DUR_REPEAT};
        endcase
        return e;
    endfunction

    // Battery pattern table.
    function automatic t_elem batt_rom(input logic [2:0] kind, input logic [1:0] step);
        t_elem e;
        e = '{color: C_NONE, dur: DUR_REPEAT};
        case (kind)
            BATT_DISCHARGING: begin
                if (step == 2'd0) e = '{color: C_NONE, dur: DUR_FOREVER};
            end
            BATT_CHARGING: begin
                if (step == 2'd0) e = '{color: C_RED, dur: DUR_FOREVER};
            end
            BATT_FULL: begin
                if (step == 2'd0) e = '{color: C_GREEN, dur: DUR_FOREVER};
            end
            BATT_OVERCHARGE: begin
                case (step)
                    2'd0: e = '{color: C_GREEN, dur: 8'd56};
                    2'd1: e = '{color: C_BLACK, dur: 8'd4};
                    default: e = '{color: C_NONE, dur: DUR_REPEAT};
                endcase
            end
            BATT_FAULT: begin
                case (step)
                    2'd0: e = '{color: C_YELLOW, dur: 8'd10};
                    2'd1: e = '{color: C_BLACK, dur: 8'd10};
                    default: e = '{color: C_NONE, dur: DUR_REPEAT};
                endcase
            end
            default: e = '{color: C_NONE, dur: DUR_REPEAT};
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/core/slps_if.sv -----
// Valid/ready channel interfaces for status items and colour results.
interface slps_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       shutdown;
    logic       shutdown_request;
    logic       high_current;
    logic       low_voltage;
    logic       ble_advertising;
    logic       ble_connected;
    logic       program_running;
    logic [1:0] charger_state;
    logic       battery_full;

    modport source (
        output valid, cmd, shutdown, shutdown_request, high_current, low_voltage,
               ble_advertising, ble_connected, program_running, charger_state,
               battery_full,
        input  ready
    );
    modport sink (
        input  valid, cmd, shutdown, shutdown_request, high_current, low_voltage,
               ble_advertising, ble_connected, program_running, charger_state,
               battery_full,
        output ready
    );
endinterface

interface slps_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] main_color;
    logic       user_control;
    logic [3:0] ble_color;
    logic [3:0] battery_color;

    modport source (
        output valid, main_color, user_control, ble_color, battery_color,
        input  ready
    );
    modport sink (
        input  valid, main_color, user_control, ble_color, battery_color,
        output ready
    );
endinterface

// ----- rtl/core/status_light_pattern_sequencer_top.sv -----
// Top level of the status light pattern sequencer: three pattern players and config port.
//
// The block takes transactions on i_in. A status transaction (cmd 0) re-selects the
// warning and Bluetooth indications and restarts both players when either changes;
// it gives no result. A tick transaction (cmd 1) advances all three players and
// gives one result on o_res with the main, Bluetooth and battery colours and the
// user-control flag.
// Each transaction is captured in an input register and handled from there by a single
// pass of table reads and compares that updates the player state and loads the result
// register. A tick's result passes through the input register and then the result
// register; one transaction is accepted every cycle while no tick waits.
// When the receiver stalls, the result register holds; a status transaction still
// goes through, while a tick waits in the input register, and i_in.ready drops only
// while that tick waits.
// Reset (synchronous, active low) clears all players to their idle indications and
// loads the register defaults. The user must write registers over the APB port only
// while no transaction is in flight; the block itself does not enforce this.
module status_light_pattern_sequencer_top
    import slps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    slps_in_if.sink     i_in,
    slps_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef struct packed {
        logic       cmd;
        logic       shutdown;
        logic       shutdown_request;
        logic       high_current;
        logic       low_voltage;
        logic       ble_advertising;
        logic       ble_connected;
        logic       program_running;
        logic [1:0] charger_state;
        logic       battery_full;
    } t_in_item;

    typedef struct packed {
        logic [3:0] main_color;
        logic       user_control;
        logic [3:0] ble_color;
        logic [3:0] battery_color;
    } t_out_item;

    typedef struct packed {
        logic [3:0] color;
        logic       adv;
        logic [7:0] ticks;
    } t_play;

    // Hub colour register value, with codes outside the blink range shown as blue.
    function automatic logic [3:0] hub_color(input logic [3:0] v);
        return (v inside {[C_HUB_LO:C_HUB_HI]}) ? v : C_BLUE;
    endfunction

    // One tick of a player on its current element.
    function automatic t_play play(input t_elem e, input logic [7:0] ticks,
                                   input logic [3:0] hub1, input logic [3:0] hub2);
        t_play      p;
        logic [7:0] t1;
        t1 = ticks + 8'd1;
        if (e.color == C_HUB1) begin
            p.color = hub_color(hub1);
        end else if (e.color == C_HUB2) begin
            p.color = hub_color(hub2);
        end else begin
            p.color = e.color;
        end
        p.adv   = 1'b0;
        p.ticks = ticks;
        if (e.dur != DUR_FOREVER) begin
            if (t1 >= e.dur) begin
                p.adv   = 1'b1;
                p.ticks = 8'd0;
            end else begin
                p.ticks = t1;
            end
        end
        return p;
    endfunction

    // Configuration registers.
    logic       r_separate_ble;
    logic       r_show_sd_req;
    logic [3:0] r_first_hub;
    logic [3:0] r_second_hub;

    // Input and result registers.
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;

    // Player state.
    logic [2:0] r_warn_kind,  n_warn_kind;
    logic [2:0] r_warn_step,  n_warn_step;
    logic [7:0] r_warn_ticks, n_warn_ticks;
    logic [1:0] r_ble_kind,   n_ble_kind;
    logic [3:0] r_ble_step,   n_ble_step;
    logic [7:0] r_ble_ticks,  n_ble_ticks;
    logic [2:0] r_batt_kind,  n_batt_kind;
    logic [1:0] r_batt_step,  n_batt_step;
    logic [7:0] r_batt_ticks, n_batt_ticks;

    logic       cfg_write;
    logic       work;
    logic [2:0] sel_warn;
    logic [1:0] sel_ble;
    logic       sel_change;
    t_out_item  n_out;

    // APB register access; writes land in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separate_ble <= 1'b0;
            r_show_sd_req  <= 1'b1;
            r_first_hub    <= C_BLUE;
            r_second_hub   <= C_BLUE;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SEPARATE_BLE: r_separate_ble <= pwdata[0];
                REG_SHOW_SD_REQ:  r_show_sd_req  <= pwdata[0];
                REG_FIRST_HUB:    r_first_hub    <= pwdata[3:0];
                REG_SECOND_HUB:   r_second_hub   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SEPARATE_BLE: prdata = {31'd0, r_separate_ble};
            REG_SHOW_SD_REQ:  prdata = {31'd0, r_show_sd_req};
            REG_FIRST_HUB:    prdata = {28'd0, r_first_hub};
            REG_SECOND_HUB:   prdata = {28'd0, r_second_hub};
            default:          prdata = 32'd0;
        endcase
    end

    // The held transaction is handled unless it is a tick facing a full result register.
    assign work       = r_in_valid && (!r_in.cmd || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || work;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= '{cmd: i_in.cmd, shutdown: i_in.shutdown,
                      shutdown_request: i_in.shutdown_request,
                      high_current: i_in.high_current, low_voltage: i_in.low_voltage,
                      ble_advertising: i_in.ble_advertising,
                      ble_connected: i_in.ble_connected,
                      program_running: i_in.program_running,
                      charger_state: i_in.charger_state, battery_full: i_in.battery_full};
        end
    end

    // Indication selection by priority for status transactions.
    always_comb begin
        if (r_in.shutdown) begin
            sel_warn = WARN_SHUTDOWN;
        end else if (r_in.shutdown_request && r_show_sd_req) begin
            sel_warn = WARN_SHUTDOWN_REQ;
        end else if (r_in.high_current) begin
            sel_warn = WARN_HIGH_CURRENT;
        end else if (r_in.low_voltage) begin
            sel_warn = WARN_LOW_VOLTAGE;
        end else begin
            sel_warn = WARN_NONE;
        end
        if (r_in.ble_advertising) begin
            sel_ble = BLE_ADVERTISING;
        end else if (r_in.ble_connected && (r_separate_ble || !r_in.program_running)) begin
            sel_ble = BLE_CONNECTED;
        end else begin
            sel_ble = BLE_NONE;
        end
        sel_change = (sel_warn != r_warn_kind) || (sel_ble != r_ble_kind);
    end

    // Player update and result formation.
    always_comb begin
        logic [2:0] wk;
        logic [1:0] bk;
        logic       restart;
        logic [2:0] ws;
        logic [7:0] wt;
        logic [3:0] bs;
        logic [7:0] bt;
        logic [1:0] as;
        logic [7:0] at;
        logic [2:0] ak;
        t_play      wp;
        t_play      bp;
        t_play      ap;
        logic [3:0] mcol;
        logic [3:0] acol;

        n_warn_kind  = r_warn_kind;
        n_warn_step  = r_warn_step;
        n_warn_ticks = r_warn_ticks;
        n_ble_kind   = r_ble_kind;
        n_ble_step   = r_ble_step;
        n_ble_ticks  = r_ble_ticks;
        n_batt_kind  = r_batt_kind;
        n_batt_step  = r_batt_step;
        n_batt_ticks = r_batt_ticks;

        // Warning player.
        wk      = (r_warn_kind < WARN_KINDS) ? r_warn_kind : WARN_NONE;
        restart = (r_warn_step >= WARN_LEN) || (warn_rom(wk, r_warn_step).dur == DUR_REPEAT);
        ws      = restart ? 3'd0 : r_warn_step;
        wt      = restart ? 8'd0 : r_warn_ticks;
        wp      = play(warn_rom(wk, ws), wt, r_first_hub, r_second_hub);

        // Bluetooth player.
        bk      = (r_ble_kind < BLE_KINDS) ? r_ble_kind : BLE_NONE;
        restart = (r_ble_step >= BLE_LEN) || (ble_rom(bk, r_ble_step).dur == DUR_REPEAT);
        bs      = restart ? 4'd0 : r_ble_step;
        bt      = restart ? 8'd0 : r_ble_ticks;
        bp      = play(ble_rom(bk, bs), bt, r_first_hub, r_second_hub);

        // Battery indication from the charger, restarting its player on change.
        case (r_in.charger_state)
            CHG_CHARGING: ak = r_in.battery_full ? BATT_FULL : BATT_CHARGING;
            CHG_COMPLETE: ak = BATT_OVERCHARGE;
            CHG_FAULT:    ak = BATT_FAULT;
            default:      ak = BATT_DISCHARGING;
        endcase
        as      = (ak != r_batt_kind) ? 2'd0 : r_batt_step;
        at      = (ak != r_batt_kind) ? 8'd0 : r_batt_ticks;
        restart = (as >= BATT_LEN) || (batt_rom(ak, as).dur == DUR_REPEAT);
        if (restart) begin
            as = 2'd0;
            at = 8'd0;
        end
        ap = play(batt_rom(ak, as), at, r_first_hub, r_second_hub);

        mcol = (!r_separate_ble && wp.color == C_NONE) ? bp.color : wp.color;
        acol = (ak == BATT_DISCHARGING) ? C_NONE : ap.color;
        n_out = '{main_color: mcol,
                  user_control: (mcol == C_NONE) && r_in.program_running,
                  ble_color: bp.color, battery_color: acol};

        if (work) begin
            if (!r_in.cmd) begin
                if (sel_change) begin
                    n_warn_kind  = sel_warn;
                    n_warn_step  = 3'd0;
                    n_warn_ticks = 8'd0;
                    n_ble_kind   = sel_ble;
                    n_ble_step   = 4'd0;
                    n_ble_ticks  = 8'd0;
                end
            end else begin
                n_warn_step  = wp.adv ? ws + 3'd1 : ws;
                n_warn_ticks = wp.ticks;
                n_ble_step   = bp.adv ? bs + 4'd1 : bs;
                n_ble_ticks  = bp.ticks;
                n_batt_kind  = ak;
                if (ak == BATT_DISCHARGING) begin
                    // A discharging battery holds its player where it stands, or resets it on entering.
                    n_batt_step  = (ak != r_batt_kind) ? 2'd0 : r_batt_step;
                    n_batt_ticks = (ak != r_batt_kind) ? 8'd0 : r_batt_ticks;
                end else begin
                    n_batt_step  = ap.adv ? as + 2'd1 : as;
                    n_batt_ticks = ap.ticks;
                end
            end
        end
    end

    // Player state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_kind  <= WARN_NONE;
            r_warn_step  <= 3'd0;
            r_warn_ticks <= 8'd0;
            r_ble_kind   <= BLE_NONE;
            r_ble_step   <= 4'd0;
            r_ble_ticks  <= 8'd0;
            r_batt_kind  <= BATT_DISCHARGING;
            r_batt_step  <= 2'd0;
            r_batt_ticks <= 8'd0;
        end else begin
            r_warn_kind  <= n_warn_kind;
            r_warn_step  <= n_warn_step;
            r_warn_ticks <= n_warn_ticks;
            r_ble_kind   <= n_ble_kind;
            r_ble_step   <= n_ble_step;
            r_ble_ticks  <= n_ble_ticks;
            r_batt_kind  <= n_batt_kind;
            r_batt_step  <= n_batt_step;
            r_batt_ticks <= n_batt_ticks;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (work && r_in.cmd) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work && r_in.cmd) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.main_color    = r_out.main_color;
    assign o_res.user_control  = r_out.user_control;
    assign o_res.ble_color     = r_out.ble_color;
    assign o_res.battery_color = r_out.battery_color;

    // A status transaction never creates a result.
    a_status_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in.cmd && !r_out_valid) |=> !r_out_valid)
        else $error("status transaction produced a result");

    // A tick that is handled always leaves a result behind.
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.cmd && (!r_out_valid || o_res.ready)) |=> r_out_valid)
        else $error("handled tick left no result");

    // A tick blocked by a stalled receiver must not move the players.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.cmd && r_out_valid && !o_res.ready)
        |=> ($stable(r_warn_step) && $stable(r_warn_ticks) && $stable(r_ble_step)
             && $stable(r_batt_step)))
        else $error("players advanced during a stall");

    // A changed indication restarts both players.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work && !r_in.cmd && sel_change)
        |=> (r_warn_step == 3'd0 && r_warn_ticks == 8'd0 && r_ble_step == 4'd0
             && r_ble_ticks == 8'd0))
        else $error("indication change did not restart the players");

endmodule
